// ===== rtl/core/svd_pkg.sv =====
// Shared types, constants and helpers for the SPH velocity divergence block.
// No dependencies; compiled first.
package svd_pkg;

	localparam int MAX_PARTICLES   = 1024;
	localparam int TABLE_INTERVALS = 1024;
	localparam int PIDX_W          = $clog2(MAX_PARTICLES);
	localparam int TADDR_W         = $clog2(TABLE_INTERVALS + 1);
	localparam int CNT_W           = 11;
	localparam int CFG_IDX_W       = 2;
	localparam int STEP_W          = 8;
	localparam int MUL_STEPS       = 64;
	localparam int DIV_STEPS       = 128;

	localparam logic [CFG_IDX_W-1:0] CFG_DIST_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 2'd1;

	localparam logic [1:0] OP_TABLE  = 2'd0;
	localparam logic [1:0] OP_RECORD = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [63:0] INV_PI  = 64'd1367130551;
	localparam logic [63:0] LIM_W   = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_64  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_48  = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] Q_LIMIT = 64'(TABLE_INTERVALS) << 16;

	typedef enum logic {AR_MUL, AR_DIV} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] vel_z;
		logic [31:0] mass;
		logic [31:0] smooth;
		logic [31:0] dens;
	} rec_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LDI, ST_RDJ, ST_LDJ, ST_SQ, ST_SQW, ST_VD, ST_VDW,
		ST_WCHK, ST_HH, ST_HHW, ST_DS, ST_DSW, ST_QD, ST_QDW, ST_TA,
		ST_TB, ST_TC, ST_PI, ST_PIW, ST_H5, ST_H5W, ST_WEND, ST_MN,
		ST_MNW, ST_TV, ST_TVW, ST_RHO, ST_RHOW, ST_OUT
	} state_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [32:0] mag33(input logic [32:0] v);
		return v[32] ? (33'd0 - v) : v;
	endfunction

	function automatic logic [63:0] clamp(input logic over, input logic [63:0] v,
			input logic [63:0] lim);
		return (over || v > lim) ? lim : v;
	endfunction

	function automatic logic [63:0] sgn(input logic [63:0] v, input logic neg);
		return neg ? (64'd0 - v) : v;
	endfunction

endpackage

// ===== rtl/core/svd_ifs.sv =====
// Request and result channel interfaces for the SPH velocity divergence block.
// Depends on nothing but the port widths of the block.
interface svd_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [10:0]        entry_index;
	logic signed [31:0] table_word;
	logic signed [31:0] position_x;
	logic signed [31:0] position_y;
	logic signed [31:0] position_z;
	logic signed [31:0] velocity_x;
	logic signed [31:0] velocity_y;
	logic signed [31:0] velocity_z;
	logic [31:0]        particle_mass;
	logic [31:0]        smoothing_length;
	logic [31:0]        particle_density;

	modport source (output valid, opcode, entry_index, table_word, position_x, position_y,
		position_z, velocity_x, velocity_y, velocity_z, particle_mass, smoothing_length,
		particle_density, input ready);
	modport sink (input valid, opcode, entry_index, table_word, position_x, position_y,
		position_z, velocity_x, velocity_y, velocity_z, particle_mass, smoothing_length,
		particle_density, output ready);
endinterface

interface svd_res_if;
	logic               valid;
	logic               ready;
	logic [9:0]         queried_index;
	logic signed [47:0] divergence;

	modport source (output valid, queried_index, divergence, input ready);
	modport sink (input valid, queried_index, divergence, output ready);
endinterface

// ===== rtl/core/svd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module svd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/svd_arith.sv =====
// Shared bit-serial unit: 64x64 multiply (64 steps) and 128/64 divide (128 steps).
// Depends on svd_pkg.
module svd_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  svd_pkg::arith_ctl_t ctl,
	input  logic [127:0]        x,
	input  logic [63:0]         y,
	output svd_pkg::arith_sts_t sts,
	output logic [127:0]        res
);
	logic                           busy_q, done_q;
	logic [svd_pkg::STEP_W-1:0]     cnt_q;
	svd_pkg::arith_op_t             op_q;
	logic [63:0]                    y_q, hi_q;
	logic [127:0]                   lo_q;
	logic [64:0]                    sum, r2, diff;
	logic                           ge;

	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, y_q} : 65'd0);
	assign r2   = {hi_q, lo_q[127]};
	assign diff = r2 - {1'b0, y_q};
	assign ge   = r2 >= {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= (ctl.op == svd_pkg::AR_MUL) ? svd_pkg::STEP_W'(svd_pkg::MUL_STEPS)
				: svd_pkg::STEP_W'(svd_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == svd_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q <= ctl.op;
			y_q  <= y;
			hi_q <= '0;
			lo_q <= x;
		end else if (busy_q) begin
			if (op_q == svd_pkg::AR_MUL) begin
				hi_q <= sum[64:1];
				lo_q <= {lo_q[127:64], sum[0], lo_q[63:1]};
			end else begin
				hi_q <= ge ? diff[63:0] : r2[63:0];
				lo_q <= {lo_q[126:0], ge};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res = (op_q == svd_pkg::AR_MUL) ? {hi_q, lo_q[63:0]} : lo_q;
endmodule

// ===== rtl/core/sph_velocity_divergence.sv =====
// SPH velocity divergence. Table and record loads are written straight into their RAMs.
// A query walks all other particles: each pair runs 14 multiplies of
// 64 steps and 12 divides of 128 steps through the one shared bit-serial arith unit
// (fewer when a weight is zero). Results wait in an output register; loads are taken
// meanwhile. Reset sets the config registers; table and record memories are not cleared.
module sph_velocity_divergence (
	input  logic                          clk,
	input  logic                          arst_n,
	svd_req_if.sink                       req,
	svd_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [svd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	svd_pkg::state_t                  state_q, state_d;
	logic [31:0]                      ds_q;
	logic [svd_pkg::CNT_W-1:0]        pc_q, cnt_eff, j_q;
	logic [svd_pkg::PIDX_W-1:0]       ix_q, rec_raddr, oidx_q;
	svd_pkg::rec_t                    ri_q, rj_q, rec_rdata, rec_wdata;
	logic                             rec_we, tbl_we, accept;
	logic [svd_pkg::TADDR_W-1:0]      tbl_raddr, idx_q;
	logic [31:0]                      tbl_rdata;
	logic [32:0]                      dr_q [3];
	logic [32:0]                      dv_q [3];
	logic [32:0]                      mdr, mdv;
	logic [1:0]                       c_q;
	logic [65:0]                      sq_q;
	logic signed [51:0]               vdr_q;
	logic [48:0]                      vmag;
	logic                             vneg, wsel_q;
	logic [2:0]                       k5_q;
	logic [63:0]                      hh_q, r_q, wi_q, wj_q, t_q, acc_q, h_cur;
	logic [63:0]                      wsum, wadj, mean, vdr64, t2, ql48, dres;
	logic [127:0]                     n_q;
	logic [15:0]                      f_q;
	logic [17:0]                      wf;
	logic signed [49:0]               p0_q;
	logic signed [50:0]               d_q;
	logic [33:0]                      shd;
	logic [64:0]                      s65;
	logic [63:0]                      acc_next;
	logic [47:0]                      div_q, odiv_q;
	logic                             out_valid_q, out_load, qrange_bad;
	svd_pkg::arith_ctl_t              actl;
	svd_pkg::arith_sts_t              asts;
	logic [127:0]                     ax, ares;
	logic [63:0]                      ay;

	assign accept  = req.valid && req.ready;
	assign cnt_eff = (pc_q > svd_pkg::CNT_W'(svd_pkg::MAX_PARTICLES))
		? svd_pkg::CNT_W'(svd_pkg::MAX_PARTICLES) : pc_q;

	assign rec_wdata = '{pos_x: req.position_x, pos_y: req.position_y, pos_z: req.position_z,
		vel_x: req.velocity_x, vel_y: req.velocity_y, vel_z: req.velocity_z,
		mass: req.particle_mass, smooth: req.smoothing_length, dens: req.particle_density};
	assign rec_we = accept && req.opcode == svd_pkg::OP_RECORD
		&& 32'(req.entry_index) < svd_pkg::MAX_PARTICLES;
	assign tbl_we = accept && req.opcode == svd_pkg::OP_TABLE
		&& 32'(req.entry_index) <= svd_pkg::TABLE_INTERVALS;

	svd_ram #(.WIDTH($bits(svd_pkg::rec_t)), .DEPTH(svd_pkg::MAX_PARTICLES)) u_rec_ram (
		.clk(clk), .we(rec_we), .waddr(req.entry_index[svd_pkg::PIDX_W-1:0]),
		.wdata(rec_wdata), .raddr(rec_raddr), .rdata(rec_rdata)
	);

	svd_ram #(.WIDTH(32), .DEPTH(svd_pkg::TABLE_INTERVALS + 1)) u_tbl_ram (
		.clk(clk), .we(tbl_we), .waddr(req.entry_index[svd_pkg::TADDR_W-1:0]),
		.wdata(req.table_word), .raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	svd_arith u_arith (
		.clk(clk), .arst_n(arst_n), .ctl(actl), .x(ax), .y(ay), .sts(asts), .res(ares)
	);

	// pair-level helpers
	assign mdr   = svd_pkg::mag33(dr_q[c_q]);
	assign mdv   = svd_pkg::mag33(dv_q[c_q]);
	assign vmag  = ares[64:16];
	assign vneg  = dr_q[c_q][32] ^ dv_q[c_q][32];
	assign h_cur = {32'd0, wsel_q ? rj_q.smooth : ri_q.smooth};
	assign wsum  = wi_q + wj_q;
	assign wadj  = wsum + {63'd0, wsum[63]};
	assign mean  = {wadj[63], wadj[63:1]};
	assign vdr64 = {{12{vdr_q[51]}}, vdr_q};
	assign shd   = ({2'b0, ds_q} & {34{sq_q[64]}}) + ({1'b0, ds_q, 1'b0} & {34{sq_q[65]}});
	assign wf    = 18'h10000 - {2'b0, f_q};
	assign qrange_bad = (ares[127:64] != 64'd0) || (ares[63:0] >= svd_pkg::Q_LIMIT);
	assign t2 = svd_pkg::sgn(svd_pkg::clamp(ares[127:96] != 32'd0, ares[95:32],
		svd_pkg::LIM_64), t_q[63] ^ vdr_q[51]);
	assign s65 = {acc_q[63], acc_q} + {t2[63], t2};
	always_comb begin
		if (!s65[64] && s65[63:0] > svd_pkg::LIM_64) begin
			acc_next = svd_pkg::LIM_64;
		end else if (s65[64] && s65 < {1'b1, 64'd0 - svd_pkg::LIM_64}) begin
			acc_next = 64'd0 - svd_pkg::LIM_64;
		end else begin
			acc_next = s65[63:0];
		end
	end
	assign ql48 = svd_pkg::clamp(ares[127:64] != 64'd0, ares[63:0], svd_pkg::LIM_48);
	assign dres = svd_pkg::sgn(ql48, !acc_q[63]);
	assign out_load = state_q == svd_pkg::ST_OUT && (!out_valid_q || res.ready);

	always_comb begin
		state_d   = state_q;
		actl      = '{start: 1'b0, op: svd_pkg::AR_MUL};
		ax        = '0;
		ay        = '0;
		rec_raddr = j_q[svd_pkg::PIDX_W-1:0];
		tbl_raddr = idx_q;
		req.ready = state_q == svd_pkg::ST_IDLE;
		case (state_q)
			svd_pkg::ST_IDLE: begin
				rec_raddr = req.entry_index[svd_pkg::PIDX_W-1:0];
				if (req.valid && req.opcode == svd_pkg::OP_QUERY && req.entry_index < cnt_eff)
					state_d = svd_pkg::ST_LDI;
			end
			svd_pkg::ST_LDI: state_d = svd_pkg::ST_RDJ;
			svd_pkg::ST_RDJ: begin
				if (j_q >= cnt_eff) state_d = svd_pkg::ST_RHO;
				else if (j_q != svd_pkg::CNT_W'(ix_q)) state_d = svd_pkg::ST_LDJ;
			end
			svd_pkg::ST_LDJ: state_d = svd_pkg::ST_SQ;
			svd_pkg::ST_SQ: begin
				actl.start = 1'b1;
				ax = 128'(mdr);
				ay = 64'(mdr);
				state_d = svd_pkg::ST_SQW;
			end
			svd_pkg::ST_SQW: begin
				if (asts.done) state_d = (c_q == 2'd2) ? svd_pkg::ST_VD : svd_pkg::ST_SQ;
			end
			svd_pkg::ST_VD: begin
				actl.start = 1'b1;
				ax = 128'(mdv);
				ay = 64'(mdr);
				state_d = svd_pkg::ST_VDW;
			end
			svd_pkg::ST_VDW: begin
				if (asts.done) state_d = (c_q == 2'd2) ? svd_pkg::ST_WCHK : svd_pkg::ST_VD;
			end
			svd_pkg::ST_WCHK: state_d = (h_cur == 64'd0) ? svd_pkg::ST_WEND : svd_pkg::ST_HH;
			svd_pkg::ST_HH: begin
				actl.start = 1'b1;
				ax = 128'(h_cur);
				ay = h_cur;
				state_d = svd_pkg::ST_HHW;
			end
			svd_pkg::ST_HHW: if (asts.done) state_d = svd_pkg::ST_DS;
			svd_pkg::ST_DS: begin
				actl.start = 1'b1;
				ax = 128'(sq_q[63:0]);
				ay = 64'(ds_q);
				state_d = svd_pkg::ST_DSW;
			end
			svd_pkg::ST_DSW: if (asts.done) state_d = svd_pkg::ST_QD;
			svd_pkg::ST_QD: begin
				actl = '{start: 1'b1, op: svd_pkg::AR_DIV};
				ax = n_q;
				ay = hh_q;
				state_d = svd_pkg::ST_QDW;
			end
			svd_pkg::ST_QDW: begin
				if (asts.done) state_d = qrange_bad ? svd_pkg::ST_WEND : svd_pkg::ST_TA;
			end
			svd_pkg::ST_TA: state_d = svd_pkg::ST_TB;
			svd_pkg::ST_TB: begin
				tbl_raddr = idx_q + 1'b1;
				state_d = svd_pkg::ST_TC;
			end
			svd_pkg::ST_TC: state_d = svd_pkg::ST_PI;
			svd_pkg::ST_PI: begin
				actl.start = 1'b1;
				ax = 128'(svd_pkg::mag64(64'(d_q)));
				ay = svd_pkg::INV_PI;
				state_d = svd_pkg::ST_PIW;
			end
			svd_pkg::ST_PIW: if (asts.done) state_d = svd_pkg::ST_H5;
			svd_pkg::ST_H5: begin
				actl = '{start: 1'b1, op: svd_pkg::AR_DIV};
				ax = {48'd0, svd_pkg::mag64(r_q), 16'd0};
				ay = h_cur;
				state_d = svd_pkg::ST_H5W;
			end
			svd_pkg::ST_H5W: begin
				if (asts.done) state_d = (k5_q == 3'd4) ? svd_pkg::ST_WEND : svd_pkg::ST_H5;
			end
			svd_pkg::ST_WEND: state_d = wsel_q ? svd_pkg::ST_MN : svd_pkg::ST_WCHK;
			svd_pkg::ST_MN: begin
				actl.start = 1'b1;
				ax = 128'(svd_pkg::mag64(mean));
				ay = 64'(rj_q.mass);
				state_d = svd_pkg::ST_MNW;
			end
			svd_pkg::ST_MNW: if (asts.done) state_d = svd_pkg::ST_TV;
			svd_pkg::ST_TV: begin
				actl.start = 1'b1;
				ax = 128'(svd_pkg::mag64(t_q));
				ay = svd_pkg::mag64(vdr64);
				state_d = svd_pkg::ST_TVW;
			end
			svd_pkg::ST_TVW: if (asts.done) state_d = svd_pkg::ST_RDJ;
			svd_pkg::ST_RHO: begin
				if (ri_q.dens == 32'd0) begin
					state_d = svd_pkg::ST_OUT;
				end else begin
					actl = '{start: 1'b1, op: svd_pkg::AR_DIV};
					ax = {48'd0, svd_pkg::mag64(acc_q), 16'd0};
					ay = 64'(ri_q.dens);
					state_d = svd_pkg::ST_RHOW;
				end
			end
			svd_pkg::ST_RHOW: if (asts.done) state_d = svd_pkg::ST_OUT;
			svd_pkg::ST_OUT: if (out_load) state_d = svd_pkg::ST_IDLE;
			default: state_d = svd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svd_pkg::ST_IDLE;
			ds_q        <= 32'd65536;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == svd_pkg::CFG_DIST_SCALE) ds_q <= cfg_data;
			if (cfg_we && cfg_index == svd_pkg::CFG_PART_COUNT)
				pc_q <= cfg_data[svd_pkg::CNT_W-1:0];
			if (out_load) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			svd_pkg::ST_IDLE: if (accept) ix_q <= req.entry_index[svd_pkg::PIDX_W-1:0];
			svd_pkg::ST_LDI: begin
				ri_q  <= rec_rdata;
				j_q   <= '0;
				acc_q <= '0;
			end
			svd_pkg::ST_RDJ: begin
				if (j_q < cnt_eff && j_q == svd_pkg::CNT_W'(ix_q)) j_q <= j_q + 1'b1;
			end
			svd_pkg::ST_LDJ: begin
				rj_q     <= rec_rdata;
				dr_q[0]  <= {ri_q.pos_x[31], ri_q.pos_x} - {rec_rdata.pos_x[31], rec_rdata.pos_x};
				dr_q[1]  <= {ri_q.pos_y[31], ri_q.pos_y} - {rec_rdata.pos_y[31], rec_rdata.pos_y};
				dr_q[2]  <= {ri_q.pos_z[31], ri_q.pos_z} - {rec_rdata.pos_z[31], rec_rdata.pos_z};
				dv_q[0]  <= {ri_q.vel_x[31], ri_q.vel_x} - {rec_rdata.vel_x[31], rec_rdata.vel_x};
				dv_q[1]  <= {ri_q.vel_y[31], ri_q.vel_y} - {rec_rdata.vel_y[31], rec_rdata.vel_y};
				dv_q[2]  <= {ri_q.vel_z[31], ri_q.vel_z} - {rec_rdata.vel_z[31], rec_rdata.vel_z};
				c_q      <= '0;
				sq_q     <= '0;
				vdr_q    <= '0;
				wsel_q   <= 1'b0;
			end
			svd_pkg::ST_SQW: begin
				if (asts.done) begin
					sq_q <= sq_q + {1'b0, ares[64:0]};
					c_q  <= (c_q == 2'd2) ? 2'd0 : c_q + 1'b1;
				end
			end
			svd_pkg::ST_VDW: begin
				if (asts.done) begin
					vdr_q <= vneg ? vdr_q - $signed({3'b0, vmag}) : vdr_q + $signed({3'b0, vmag});
					c_q   <= c_q + 1'b1;
				end
			end
			svd_pkg::ST_WCHK: if (h_cur == 64'd0) r_q <= '0;
			svd_pkg::ST_HHW: if (asts.done) hh_q <= ares[63:0];
			svd_pkg::ST_DSW: if (asts.done) n_q <= ares + {30'd0, shd, 64'd0};
			svd_pkg::ST_QDW: begin
				if (asts.done) begin
					if (qrange_bad) r_q <= '0;
					idx_q <= ares[16 +: svd_pkg::TADDR_W];
					f_q   <= ares[15:0];
				end
			end
			svd_pkg::ST_TB: p0_q <= $signed(wf) * $signed(tbl_rdata);
			svd_pkg::ST_TC: d_q <= p0_q + $signed({2'b0, f_q}) * $signed(tbl_rdata);
			svd_pkg::ST_PIW: begin
				if (asts.done) begin
					r_q  <= svd_pkg::sgn(svd_pkg::clamp(ares[127:96] != 32'd0, ares[95:32],
						svd_pkg::LIM_W), d_q[50]);
					k5_q <= '0;
				end
			end
			svd_pkg::ST_H5W: begin
				if (asts.done) begin
					r_q  <= svd_pkg::sgn(svd_pkg::clamp(ares[127:64] != 64'd0, ares[63:0],
						svd_pkg::LIM_W), r_q[63]);
					k5_q <= k5_q + 1'b1;
				end
			end
			svd_pkg::ST_WEND: begin
				if (!wsel_q) begin
					wi_q   <= r_q;
					wsel_q <= 1'b1;
				end else begin
					wj_q <= r_q;
				end
			end
			svd_pkg::ST_MNW: begin
				if (asts.done)
					t_q <= svd_pkg::sgn(svd_pkg::clamp(ares[127:80] != 48'd0, ares[79:16],
						svd_pkg::LIM_64), mean[63]);
			end
			svd_pkg::ST_TVW: begin
				if (asts.done) begin
					acc_q <= acc_next;
					j_q   <= j_q + 1'b1;
				end
			end
			svd_pkg::ST_RHO: if (ri_q.dens == 32'd0) div_q <= '0;
			svd_pkg::ST_RHOW: if (asts.done) div_q <= dres[47:0];
			svd_pkg::ST_OUT: begin
				if (out_load) begin
					oidx_q <= ix_q;
					odiv_q <= div_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid         = out_valid_q;
	assign res.queried_index = 10'(oidx_q);
	assign res.divergence    = odiv_q;
endmodule
